// ===== design/url_query_redactor_core_macros.svh =====
// assertion macros shared by the checker file
`ifndef URL_QUERY_REDACTOR_CORE_MACROS_SVH
`define URL_QUERY_REDACTOR_CORE_MACROS_SVH

// next-cycle implication, ignored while reset is asserted
`define URLQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("url query redactor check failed");

// next-cycle implication that also checks across reset
`define URLQR_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("url query redactor reset check failed");

`endif

// ===== design/urlqr_pkg.sv =====
// shared types, constants and byte tables of the url query redactor
`default_nettype none

package urlqr_pkg;

  localparam int SCHEME_LEN = 14;
  localparam int MARK_LEN   = 10;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int MATCH_W    = 4;

  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  // command from the front to the back: one byte, optionally followed by the marker
  typedef struct packed {
    logic [7:0] ch;
    logic       redact;
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_SEARCH = 3'b001,
    MODE_URL    = 3'b010,
    MODE_DROP   = 3'b100
  } mode_t;

  function automatic logic [7:0] scheme_byte(input logic [MATCH_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = "p";
      4'd1:    b = "r";
      4'd2:    b = "u";
      4'd3:    b = "s";
      4'd4:    b = "a";
      4'd5:    b = "s";
      4'd6:    b = "l";
      4'd7:    b = "i";
      4'd8:    b = "c";
      4'd9:    b = "e";
      4'd10:   b = "r";
      4'd11:   b = ":";
      4'd12:   b = "/";
      4'd13:   b = "/";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] mark_byte(input logic [MATCH_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = "<";
      4'd1:    b = "r";
      4'd2:    b = "e";
      4'd3:    b = "d";
      4'd4:    b = "a";
      4'd5:    b = "c";
      4'd6:    b = "t";
      4'd7:    b = "e";
      4'd8:    b = "d";
      4'd9:    b = ">";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == 8'h22) || (c == 8'h5C) || (c == 8'h20) ||
           (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

endpackage

`default_nettype wire

// ===== design/urlqr_fifo.sv =====
// short command queue between the classifying front and the emitting back
`default_nettype none

module urlqr_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire urlqr_pkg::cmd_t wr_cmd,
  input  wire logic          pop,
  output urlqr_pkg::cmd_t    rd_cmd,
  output logic               full,
  output logic               empty
);
  import urlqr_pkg::*;

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== design/urlqr_front.sv =====
// front: scheme matching, url tracking and classification of each item
`default_nettype none

module urlqr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire urlqr_pkg::in_item_t item,
  output logic                   cmd_push,
  output urlqr_pkg::cmd_t        cmd
);
  import urlqr_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [MATCH_W-1:0] match_r, match_nxt;
  logic [MATCH_W-1:0] m;
  logic [7:0]         c;
  logic               emit;

  assign c = item.in_char;

  always_comb begin
    mode_nxt   = mode_r;
    match_nxt  = match_r;
    emit       = 1'b0;
    cmd.ch     = c;
    cmd.redact = 1'b0;
    m          = (match_r >= MATCH_W'(SCHEME_LEN)) ? '0 : match_r;
    unique case (mode_r)
      MODE_URL: begin
        emit = 1'b1;
        if (is_term(c)) begin
          mode_nxt  = MODE_SEARCH;
          match_nxt = '0;
        end else if (c == CH_QMARK) begin
          cmd.redact = 1'b1;
          mode_nxt   = MODE_DROP;
        end
      end
      MODE_DROP: begin
        if (is_term(c)) begin
          emit      = 1'b1;
          mode_nxt  = MODE_SEARCH;
          match_nxt = '0;
        end
      end
      default: begin
        emit     = 1'b1;
        mode_nxt = MODE_SEARCH;
        if (c == scheme_byte(m)) begin
          if (m == MATCH_W'(SCHEME_LEN - 1)) begin
            mode_nxt  = MODE_URL;
            match_nxt = '0;
          end else begin
            match_nxt = m + MATCH_W'(1);
          end
        end else begin
          match_nxt = (c == scheme_byte('0)) ? MATCH_W'(1) : '0;
        end
      end
    endcase
    if (item.end_of_text) begin
      mode_nxt  = MODE_SEARCH;
      match_nxt = '0;
    end
  end

  assign cmd_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SEARCH;
      match_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      match_r <= match_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/urlqr_back.sv =====
// back: expands commands into output bytes and holds the output register
`default_nettype none

module urlqr_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire urlqr_pkg::cmd_t head,
  input  wire logic            head_empty,
  output logic                 head_pop,
  input  wire logic            out_pop,
  output logic                 out_empty,
  output urlqr_pkg::out_item_t out_data
);
  import urlqr_pkg::*;

  logic               valid_r, valid_nxt;
  out_item_t          data_r, data_nxt;
  logic               burst_r, burst_nxt;
  logic [MATCH_W-1:0] idx_r, idx_nxt;
  logic               load;

  assign out_empty = !valid_r;
  assign out_data  = data_r;
  assign load      = !valid_r || out_pop;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    burst_nxt = burst_r;
    idx_nxt   = idx_r;
    head_pop  = 1'b0;
    if (load) begin
      if (burst_r) begin
        valid_nxt         = 1'b1;
        data_nxt.out_char = mark_byte(idx_r);
        data_nxt.run_last = (idx_r == MATCH_W'(MARK_LEN - 1));
        idx_nxt           = idx_r + MATCH_W'(1);
        if (idx_r == MATCH_W'(MARK_LEN - 1)) begin
          burst_nxt = 1'b0;
        end
      end else if (!head_empty) begin
        valid_nxt         = 1'b1;
        data_nxt.out_char = head.ch;
        data_nxt.run_last = !head.redact;
        head_pop          = 1'b1;
        burst_nxt         = head.redact;
        idx_nxt           = '0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      burst_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      burst_r <= burst_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== design/url_query_redactor_core.sv =====
// top level of the url query redactor: front, command queue and back
//
// usage
// - input channel is a queue write port: an item (one text byte plus an
//   end_of_text flag) is taken when in_push is high and in_full is low
// - result channel is a queue read port: while out_empty is low the oldest
//   output byte sits on out_data, and it is taken when out_pop is high
// - each item yields no byte (dropped query byte), one byte, or eleven bytes
//   ('?' followed by the marker <redacted>); run_last flags the final byte
//   of each item
// - path: the front classifies an item combinationally when it is taken and
//   writes its command into the queue; the back then loads the byte from
//   the queue into the output register, which drives out_data
// - throughput: one item per cycle while bytes pass one for one; a redaction
//   burst holds the back for the marker, dropped query bytes need no queue
//   space, other items fill the 4-entry queue and then in_full rises
// - reset (rst_n low, synchronous) clears the match state, the queue and
//   the output valid flag; in_full stays low through reset
// - if the receiver stalls, the output register holds and in_full rises once the queue fills
`default_nettype none

module url_query_redactor_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire urlqr_pkg::in_item_t  in_data,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output urlqr_pkg::out_item_t      out_data
);
  import urlqr_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  cmd_t head;
  logic head_empty;
  logic head_pop;
  logic q_full;

  // queue full stalls the whole input, even for items that would be dropped
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  urlqr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  urlqr_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd),
    .pop    (head_pop),
    .rd_cmd (head),
    .full   (q_full),
    .empty  (head_empty)
  );

  urlqr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== design/urlqr_checker.sv =====
// port-level checks of the url query redactor, bound to the top level
`default_nettype none

`include "url_query_redactor_core_macros.svh"

module urlqr_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_full,
  input wire logic                 out_empty,
  input wire logic                 out_pop,
  input wire urlqr_pkg::out_item_t out_data
);
  import urlqr_pkg::*;

  logic out_take;
  logic qmark_take;

  assign out_take   = out_pop && !out_empty;
  assign qmark_take = out_take && (out_data.out_char == CH_QMARK) && !out_data.run_last;

  // reset leaves nothing to read and room to write
  `URLQR_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n, out_empty && !in_full)

  // a stalled byte holds
  `URLQR_ASSERT_NEXT(a_stall_holds, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_data))

  // a byte that is not the last of its item is followed at once by another
  `URLQR_ASSERT_NEXT(a_burst_continues, clk, rst_n, out_take && !out_data.run_last, !out_empty)

  // the query mark is followed directly by the marker opening
  `URLQR_ASSERT_NEXT(a_marker_opens, clk, rst_n, qmark_take, out_data.out_char == 8'h3C)

endmodule

bind url_query_redactor_core urlqr_checker u_urlqr_checker (.*);

`default_nettype wire

// ===== tb/url_query_redactor_core_tb.sv =====
// testbench for url_query_redactor_core: random texts through both queue ports, checked per byte
`default_nettype none

module url_query_redactor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urlqr_pkg::*;

  // the scheme literal, first byte in the top lane
  localparam logic [SCHEME_LEN*8-1:0] SCHEME_HEX = {
    8'h70, 8'h72, 8'h75, 8'h73, 8'h61, 8'h73, 8'h6C,
    8'h69, 8'h63, 8'h65, 8'h72, 8'h3A, 8'h2F, 8'h2F
  };
  localparam logic [MARK_LEN*8-1:0] MARKER_TEXT = "<redacted>";

  // bytes that close a url
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam int MAX_SHOWN = 10;

  function automatic logic [7:0] scheme_at(input int idx);
    return SCHEME_HEX[8*(SCHEME_LEN-1-idx) +: 8];
  endfunction

  function automatic logic ends_url(input logic [7:0] c);
    case (c)
      CH_DQUOTE, CH_BSLASH, CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // predicts the output bytes of each accepted item and checks them in order
  class redaction_scoreboard;
    logic [MATCH_W-1:0] match_len;
    mode_t              mode;
    out_item_t          expected_bytes[$];
    int                 faults;

    function new();
      match_len = '0;
      mode      = MODE_SEARCH;
      faults    = 0;
    endfunction

    function void add_byte(input logic [7:0] c, input logic last);
      out_item_t o;
      o.out_char = c;
      o.run_last = last;
      expected_bytes.push_back(o);
    endfunction

    // returns how many output bytes the item causes
    function int note_input(input in_item_t it);
      logic [7:0] c;
      int         size_at_start;
      c             = it.in_char;
      size_at_start = expected_bytes.size();
      case (mode)
        MODE_URL: begin
          if (ends_url(c)) begin
            add_byte(c, 1'b1);
            mode      = MODE_SEARCH;
            match_len = '0;
          end else if (c == CH_QMARK) begin
            add_byte(c, 1'b0);
            for (int i = 0; i < MARK_LEN; i++)
              add_byte(MARKER_TEXT[8*(MARK_LEN-1-i) +: 8], i == MARK_LEN - 1);
            mode = MODE_DROP;
          end else begin
            add_byte(c, 1'b1);
          end
        end
        MODE_DROP: begin
          if (ends_url(c)) begin
            add_byte(c, 1'b1);
            mode      = MODE_SEARCH;
            match_len = '0;
          end
        end
        default: begin
          add_byte(c, 1'b1);
          if (c == scheme_at(int'(match_len))) begin
            if (match_len == MATCH_W'(SCHEME_LEN - 1)) begin
              mode      = MODE_URL;
              match_len = '0;
            end else begin
              match_len = match_len + MATCH_W'(1);
            end
          end else begin
            match_len = (c == scheme_at(0)) ? MATCH_W'(1) : '0;
          end
        end
      endcase
      if (it.end_of_text) begin
        mode      = MODE_SEARCH;
        match_len = '0;
      end
      return expected_bytes.size() - size_at_start;
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        faults++;
        if (faults <= MAX_SHOWN)
          $display("%0t: unexpected byte %h run_last %b", $realtime, got.out_char,
                   got.run_last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_char !== want.out_char || got.run_last !== want.run_last) begin
        faults++;
        if (faults <= MAX_SHOWN)
          $display("%0t: byte mismatch, expected %h/%b got %h/%b", $realtime,
                   want.out_char, want.run_last, got.out_char, got.run_last);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;

  redaction_scoreboard sb = new();

  // idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // items that produced at least one byte
  int busy_items = 0;

  url_query_redactor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // receiver: random pop with the current idle rate, one assignment per edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: both handshakes sampled at the edge, before any nonblocking update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        if (sb.note_input(in_data) != 0)
          busy_items++;
      end
      if (out_pop && !out_empty)
        sb.check_result(out_data);
    end
  end

  // offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_byte(input logic [7:0] c, input logic eot);
    in_item_t it;
    it.in_char     = c;
    it.end_of_text = eot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    // full sampled before this edge's updates decides acceptance
    while (in_full)
      @(posedge clk);
  endtask

  function automatic logic [7:0] pick_terminator();
    case ($urandom_range(5))
      0:       return CH_DQUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SPACE;
      3:       return CH_TAB;
      4:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // one random text: mostly a url with a query, sometimes broken, sometimes noise
  task automatic send_text();
    int         broken_at;
    int         n;
    logic [7:0] c;
    if ($urandom_range(99) < 15) begin
      // raw noise over the full byte range
      n = $urandom_range(6, 1);
      repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      return;
    end
    // a little leading text
    n = $urandom_range(3);
    repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
    // scheme, cut short by a wrong byte in one of five texts
    broken_at = ($urandom_range(99) < 20) ? $urandom_range(SCHEME_LEN - 1) : SCHEME_LEN;
    for (int i = 0; i < SCHEME_LEN; i++) begin
      if (i == broken_at) begin
        c = ($urandom_range(3) == 0) ? scheme_at(0) : 8'($urandom_range(255));
        send_byte(c, $urandom_range(5) == 0);
        break;
      end
      send_byte(scheme_at(i), 1'b0);
    end
    // url body in printable ascii
    n = $urandom_range(6);
    repeat (n) send_byte(8'($urandom_range(8'h7E, 8'h21)), 1'b0);
    // query part, later marks and bytes get dropped
    if ($urandom_range(99) < 70) begin
      send_byte(CH_QMARK, 1'b0);
      n = $urandom_range(5);
      repeat (n) begin
        c = ($urandom_range(7) == 0) ? CH_QMARK : 8'($urandom_range(255));
        send_byte(c, 1'b0);
      end
    end
    // close with a terminator, or end the text right away
    if ($urandom_range(99) < 80)
      send_byte(pick_terminator(), $urandom_range(3) == 0);
    else
      send_byte(8'($urandom_range(8'h7E, 8'h21)), 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, restart on a repeated first byte, full scheme
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(scheme_at(0), 1'b0);
    for (int i = 0; i < SCHEME_LEN; i++)
      send_byte(scheme_at(i), 1'b0);
    // scheme start inside a url passes through
    send_byte(scheme_at(0), 1'b0);
    // first query mark brings the marker, the second is dropped like the rest
    send_byte(CH_QMARK, 1'b0);
    send_byte(CH_QMARK, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte("x", 1'b1);
    // end of text in the middle of a partial match clears it
    send_byte(scheme_at(0), 1'b0);
    send_byte(scheme_at(1), 1'b1);
    send_byte(scheme_at(2), 1'b0);

    // random phases: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      int target;
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = busy_items + 36;
      while (busy_items < target)
        send_text();
    end
    in_push <= 1'b0;

    // drain every expected byte, then a few cycles for strays
    while (sb.expected_bytes.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.faults == 0) begin
      $display("url_query_redactor_core_tb: done, clean");
    end else begin
      $display("url_query_redactor_core_tb: done, errors");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #4ms;
    $display("url_query_redactor_core_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
